// ----- sv/bpsa_pkg.sv -----
package bpsa_pkg;

  localparam int LIMBS       = 64;
  localparam int RADIX       = 10000;
  localparam int FAC_LIMBS   = 5;
  localparam int LIMB_W      = 14;
  localparam int MAG_W       = 64;
  localparam int AW          = $clog2(LIMBS);
  localparam int LEN_W       = $clog2(LIMBS + 1);
  localparam int COL_W       = $clog2(LIMBS + FAC_LIMBS + 1);
  localparam int ACC_W       = 30;
  localparam int Q_W         = 17;
  localparam int RECIP_SHIFT = 43;
  localparam int PROD_W      = 2 * ACC_W;
  localparam int POS_W       = 6;
  localparam int SIGN_W      = 2;
  localparam int IN_W        = 64;
  localparam int OUT_W       = 88;

  localparam logic [ACC_W-1:0]  RECIP     = ACC_W'(879609303);
  localparam logic [SIGN_W-1:0] SIGN_ZERO = 2'b00;
  localparam logic [SIGN_W-1:0] SIGN_POS  = 2'b01;
  localparam logic [SIGN_W-1:0] SIGN_NEG  = 2'b11;

  typedef logic [LIMB_W-1:0] limb_t;
  typedef limb_t [FAC_LIMBS-1:0] digits_t;

  typedef struct packed {
    logic              pad;
    logic              overflow;
    logic [POS_W-1:0]  position;
    limb_t             limb;
    logic [SIGN_W-1:0] product_sign;
    logic [63:0]       sum;
  } out_item_t;

endpackage

// ----- sv/bignum_product_and_sum_accumulator.sv -----
// Accumulates a wrapping 64-bit sum and a signed base-10000 product over a set of
// numbers; an item with tlast set ends the set and emits one result per product
// limb, most significant first, then restarts at sum 0 and product +1. Items are
// taken one at a time. A zero factor, or a product already zero, skips the
// multiplication. Any other factor first goes through a bit-serial binary to
// base-10000 conversion of all 64 bits, then one column for each of the L + 5
// result limbs, L being the product's current limb count, each column five
// multiply-accumulate steps through the single 14x14 multiplier plus a read of
// the limb store and a pipelined divide by 10000. Emission reads each limb
// through the limb store's read port, and stalls only while the output register
// is full. Limbs beyond 64 are dropped; nonzero ones set the sticky overflow bit.
module bignum_product_and_sum_accumulator (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [bpsa_pkg::IN_W-1:0]  s_axis_tdata,  // value[63:0]
  input  logic                       s_axis_tlast,  // end_of_set
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [bpsa_pkg::OUT_W-1:0] m_axis_tdata,  // sum, product_sign, limb,
                                                    // limb_position, overflow, zero pad
  output logic                       m_axis_tlast   // last
);
  import bpsa_pkg::*;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_CONV    = 3'd1;
  localparam logic [2:0] ST_COL     = 3'd2;
  localparam logic [2:0] ST_DIV     = 3'd3;
  localparam logic [2:0] ST_EMIT_RD = 3'd4;
  localparam logic [2:0] ST_EMIT_LD = 3'd5;

  localparam logic [2:0] PH_DIV = 3'd5;

  logic [2:0]        state;
  logic [63:0]       sum;
  logic [SIGN_W-1:0] sign;
  logic [LEN_W-1:0]  length;
  logic              one;
  logic              overflow;
  logic              eos;
  logic              neg;
  logic [COL_W-1:0]  k;
  logic [2:0]        phase;
  logic [ACC_W-1:0]  acc;
  logic [Q_W-1:0]    carry;
  logic [LEN_W-1:0]  top;
  limb_t             win [FAC_LIMBS];
  logic              rd_live;
  logic              rd_one;
  logic [AW-1:0]     pos;
  out_item_t         out_item;
  logic              out_valid;

  logic              in_fire;
  logic [63:0]       mag;
  logic              conv_start;
  logic              conv_done;
  digits_t           digits;
  logic              dm_start;
  logic              dm_done;
  logic [Q_W-1:0]    dm_q;
  limb_t             dm_r;
  logic              ram_we;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  limb_t             ram_rdata;
  limb_t             rd_eff;
  limb_t             mac_a;
  limb_t             mac_b;
  logic [2*LIMB_W-1:0] mac_p;
  logic [ACC_W-1:0]  acc_next;
  logic [COL_W-1:0]  k_next;
  logic [LEN_W-1:0]  top_next;
  logic              col_in_store;
  logic              col_last;
  logic              emit_load;

  assign s_axis_tready = (state == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign mag           = s_axis_tdata[63] ? (~s_axis_tdata + 64'd1) : s_axis_tdata;
  assign conv_start    = in_fire && (mag != '0) && (sign != SIGN_ZERO);
  assign dm_start      = (state == ST_COL) && (phase == PH_DIV);

  assign rd_eff   = rd_live ? (rd_one ? LIMB_W'(1) : ram_rdata) : '0;
  assign mac_a    = (phase == 3'd0) ? rd_eff : win[phase];
  assign mac_b    = digits[phase];
  assign mac_p    = mac_a * mac_b;
  assign acc_next = ((phase == 3'd0) ? ACC_W'(carry) : acc) + ACC_W'(mac_p);

  assign k_next       = k + 1'b1;
  assign col_in_store = (k < COL_W'(LIMBS));
  assign col_last     = (k == COL_W'(length) + COL_W'(FAC_LIMBS - 1));
  assign top_next     = (col_in_store && dm_r != '0) ? LEN_W'(k) + 1'b1 : top;
  assign ram_we       = (state == ST_DIV) && dm_done && col_in_store;
  assign emit_load    = (state == ST_EMIT_LD) && (!out_valid || m_axis_tready);

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = '0;
    if (state == ST_CONV && conv_done) begin
      ram_re = 1'b1;
    end else if (state == ST_DIV && dm_done && !col_last
                 && k_next < COL_W'(length)) begin
      ram_re    = 1'b1;
      ram_raddr = k_next[AW-1:0];
    end else if (state == ST_EMIT_RD) begin
      ram_re    = 1'b1;
      ram_raddr = pos;
    end
  end

  bpsa_limb_ram #(
    .DEPTH(LIMBS),
    .WIDTH(LIMB_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (k[AW-1:0]),
    .wdata (dm_r),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bpsa_radix_conv u_conv (
    .clk    (clk),
    .rst    (rst),
    .start  (conv_start),
    .mag    (mag),
    .done   (conv_done),
    .digits (digits)
  );

  bpsa_divmod u_divmod (
    .clk   (clk),
    .rst   (rst),
    .start (dm_start),
    .acc   (acc),
    .done  (dm_done),
    .quot  (dm_q),
    .rem   (dm_r)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      sum       <= '0;
      sign      <= SIGN_POS;
      length    <= LEN_W'(1);
      one       <= 1'b1;
      overflow  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && m_axis_tready && !emit_load) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            sum <= sum + s_axis_tdata;
            eos <= s_axis_tlast;
            neg <= s_axis_tdata[63];
            if (conv_start) begin
              state <= ST_CONV;
            end else begin
              sign   <= SIGN_ZERO;
              length <= LEN_W'(1);
              one    <= 1'b0;
              pos    <= '0;
              if (s_axis_tlast) begin
                state <= ST_EMIT_RD;
              end
            end
          end
        end
        ST_CONV: begin
          if (conv_done) begin
            k       <= '0;
            phase   <= '0;
            top     <= '0;
            rd_live <= 1'b1;
            rd_one  <= one;
            state   <= ST_COL;
          end
        end
        ST_COL: begin
          if (phase == PH_DIV) begin
            state <= ST_DIV;
          end else begin
            acc   <= acc_next;
            phase <= phase + 1'b1;
          end
        end
        ST_DIV: begin
          if (dm_done) begin
            top <= top_next;
            if (!col_in_store && dm_r != '0) begin
              overflow <= 1'b1;
            end
            if (col_last) begin
              one <= 1'b0;
              if (top_next == '0) begin
                sign   <= SIGN_ZERO;
                length <= LEN_W'(1);
                pos    <= '0;
              end else begin
                length <= top_next;
                pos    <= AW'(top_next - 1'b1);
                if (neg) begin
                  sign <= ~sign + 2'd1;
                end
              end
              state <= eos ? ST_EMIT_RD : ST_IDLE;
            end else begin
              k       <= k_next;
              phase   <= '0;
              rd_live <= (k_next < COL_W'(length));
              rd_one  <= 1'b0;
              state   <= ST_COL;
            end
          end
        end
        ST_EMIT_RD: begin
          state <= ST_EMIT_LD;
        end
        ST_EMIT_LD: begin
          if (emit_load) begin
            out_valid <= 1'b1;
            if (pos == '0) begin
              sum      <= '0;
              sign     <= SIGN_POS;
              length   <= LEN_W'(1);
              one      <= 1'b1;
              overflow <= 1'b0;
              state    <= ST_IDLE;
            end else begin
              pos   <= pos - 1'b1;
              state <= ST_EMIT_RD;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DIV && dm_done) begin
      carry <= dm_q;
    end else if (state == ST_CONV) begin
      carry <= '0;
      for (int i = 0; i < FAC_LIMBS; i++) begin
        win[i] <= '0;
      end
    end else if (state == ST_COL && phase == 3'd0) begin
      win[0] <= rd_eff;
      for (int i = 1; i < FAC_LIMBS; i++) begin
        win[i] <= win[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_item.pad          <= 1'b0;
      out_item.overflow     <= overflow;
      out_item.position     <= POS_W'(pos);
      out_item.product_sign <= sign;
      out_item.sum          <= sum;
      if (sign == SIGN_ZERO) begin
        out_item.limb <= '0;
      end else if (one && pos == '0) begin
        out_item.limb <= LIMB_W'(1);
      end else begin
        out_item.limb <= ram_rdata;
      end
      m_axis_tlast <= (pos == '0);
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_item;

`ifndef NO_ASSERTIONS
  a_limb_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> out_item.limb < LIMB_W'(RADIX))
    else $error("emitted limb out of range");

  a_length_range: assert property (@(posedge clk) disable iff (rst)
    length != '0 && LEN_W'(length) <= LEN_W'(LIMBS))
    else $error("limb count out of range");

  a_zero_single: assert property (@(posedge clk) disable iff (rst)
    sign == SIGN_ZERO |-> length == LEN_W'(1))
    else $error("zero product with more than one limb");

  a_sign_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> out_item.product_sign != 2'b10)
    else $error("invalid product sign code");

  a_div_timing: assert property (@(posedge clk) disable iff (rst)
    dm_done |-> state == ST_DIV && $past(state, 3) == ST_COL)
    else $error("divide result outside column step");
`endif

endmodule

// ----- sv/bpsa_limb_ram.sv -----
module bpsa_limb_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 14
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/bpsa_radix_conv.sv -----
module bpsa_radix_conv (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [bpsa_pkg::MAG_W-1:0] mag,
  output logic                     done,
  output bpsa_pkg::digits_t        digits
);
  import bpsa_pkg::*;

  localparam int CNT_W = $clog2(MAG_W);

  logic [MAG_W-1:0] shreg;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  digits_t          digits_next;

  always_comb begin
    logic                carry;
    logic [LIMB_W:0]     dbl;
    carry = shreg[MAG_W-1];
    for (int d = 0; d < FAC_LIMBS; d++) begin
      dbl = {digits[d], carry};
      if (dbl >= (LIMB_W+1)'(RADIX)) begin
        digits_next[d] = LIMB_W'(dbl - (LIMB_W+1)'(RADIX));
        carry = 1'b1;
      end else begin
        digits_next[d] = dbl[LIMB_W-1:0];
        carry = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(MAG_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg  <= mag;
      digits <= '0;
    end else if (busy) begin
      shreg  <= {shreg[MAG_W-2:0], 1'b0};
      digits <= digits_next;
    end
  end

endmodule

// ----- sv/bpsa_divmod.sv -----
module bpsa_divmod (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [bpsa_pkg::ACC_W-1:0] acc,
  output logic                       done,
  output logic [bpsa_pkg::Q_W-1:0]   quot,
  output bpsa_pkg::limb_t            rem
);
  import bpsa_pkg::*;

  logic              s1_valid;
  logic [ACC_W-1:0]  s1_acc;
  logic [Q_W-1:0]    s1_q;
  logic [PROD_W-1:0] prod;
  logic [ACC_W:0]    diff;
  logic [ACC_W:0]    qmul;

  assign prod = acc * RECIP;
  assign qmul = (ACC_W+1)'(s1_q) * (ACC_W+1)'(RADIX);
  assign diff = (ACC_W+1)'(s1_acc) - qmul;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      s1_valid <= start;
      done     <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      s1_acc <= acc;
      s1_q   <= prod[RECIP_SHIFT +: Q_W];
    end
    if (s1_valid) begin
      if (diff >= (ACC_W+1)'(RADIX)) begin
        rem  <= LIMB_W'(diff - (ACC_W+1)'(RADIX));
        quot <= s1_q + 1'b1;
      end else begin
        rem  <= LIMB_W'(diff);
        quot <= s1_q;
      end
    end
  end

endmodule
